// ===== sv/oss_pkg.sv =====
// Shared constants and types for the OFDM symbol sampler.
package oss_pkg;

   localparam int FFT_LEN    = 64;
   localparam int CP_MAX     = 16;
   localparam int RING_DEPTH = 128;

   localparam int RING_AW = $clog2(RING_DEPTH);
   localparam int CNT_W   = $clog2(RING_DEPTH + 1);
   localparam int J_W     = $clog2(FFT_LEN + CP_MAX + 1);
   localparam int K_W     = $clog2(FFT_LEN);
   localparam int CP_W    = 5;
   localparam int TO_W    = 16;
   localparam int SMP_W   = 16;
   localparam int IDX_W   = 6;
   localparam int CMDQ_DEPTH = 2;

   localparam logic REG_PREFIX_LEN    = 1'b0;
   localparam logic REG_TIMEOUT_LIMIT = 1'b1;

   typedef struct packed {
      logic                    trigger;
      logic signed [SMP_W-1:0] q;
      logic signed [SMP_W-1:0] i;
   } ring_entry_type;

   typedef struct packed {
      logic [RING_AW-1:0] start;
      logic               preamble;
   } emit_cmd_type;

endpackage

// ===== sv/oss_cmd_fifo.sv =====
// Short queue of emission commands between the window closer and the emitter.
module oss_cmd_fifo
   import oss_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  emit_cmd_type push_data,
   input  logic         pop,
   output emit_cmd_type pop_data,
   output logic         not_empty
);

   localparam int PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CNT_BITS = $clog2(CMDQ_DEPTH + 1);

   emit_cmd_type       mem_ff [CMDQ_DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   assign not_empty = (cnt_ff != '0);
   assign pop_data  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/oss_front.sv =====
// Sample ring, window tracking and window closing with trigger scan.
module oss_front
   import oss_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [SMP_W-1:0] req_sample_i,
   input  logic signed [SMP_W-1:0] req_sample_q,
   input  logic                    req_trigger,
   input  logic [CP_W-1:0]         prefix_len,
   input  logic [TO_W-1:0]         timeout_limit,
   input  logic                    back_busy,
   output logic                    cmd_push,
   output emit_cmd_type            cmd_data,
   input  logic [RING_AW-1:0]      emit_addr,
   output ring_entry_type          emit_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_EVAL  = 2'd3;

   ring_entry_type ring_mem [RING_DEPTH];
   ring_entry_type scan_data_ff, emit_data_ff;

   logic [1:0]         state_ff, state_in;
   logic [RING_AW-1:0] wp_ff, wp_in, ws_ff, ws_in;
   logic               locked_ff, locked_in;
   logic [TO_W-1:0]    tc_ff, tc_in;
   logic               pend_ff, pend_in;
   logic               zt_ff, zt_in;
   logic [J_W-1:0]     j_ff, j_in;
   logic               have_ff, have_in;
   logic               pre_ff, pre_in;

   logic [CNT_W-1:0]   cp_eff;
   logic [CNT_W-1:0]   win_len;
   logic [CNT_W-1:0]   filled;
   logic [RING_AW-1:0] scan_addr;
   logic               accept;
   logic               take;
   logic               keep;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || back_busy;
   assign cp_eff    = (CNT_W'(prefix_len) > CNT_W'(CP_MAX)) ? CNT_W'(CP_MAX)
                                                            : CNT_W'(prefix_len);
   assign win_len   = CNT_W'(FFT_LEN) + cp_eff;
   assign filled    = CNT_W'(RING_AW'(wp_ff - ws_ff));
   assign scan_addr = ws_ff + RING_AW'(j_ff);
   assign emit_data = emit_data_ff;
   assign cmd_data  = '{start: ws_ff, preamble: pre_ff};

   always_comb begin
      state_in  = state_ff;
      wp_in     = wp_ff;
      ws_in     = ws_ff;
      locked_in = locked_ff;
      tc_in     = tc_ff;
      pend_in   = pend_ff;
      zt_in     = zt_ff;
      j_in      = j_ff;
      have_in   = have_ff;
      pre_in    = pre_ff;
      cmd_push  = 1'b0;
      take      = 1'b0;
      keep      = have_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               wp_in    = wp_ff + 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (filled < win_len) begin
               state_in = ST_IDLE;
            end else begin
               have_in = 1'b0;
               pre_in  = 1'b0;
               if (locked_ff) begin
                  tc_in = tc_ff - 1'b1;
                  if (tc_in == '0) begin
                     locked_in = 1'b0;
                  end else begin
                     have_in = 1'b1;
                     pre_in  = pend_ff;
                     pend_in = 1'b0;
                  end
               end
               j_in     = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            // A trigger inside the prefix is skipped for a preamble candidate
            // and otherwise drops the candidate.
            if (scan_data_ff.trigger && !(j_ff == '0 && zt_ff)) begin
               if (CNT_W'(j_ff) <= cp_eff && have_ff) begin
                  if (!pre_ff) begin
                     keep = 1'b0;
                     take = 1'b1;
                  end
               end else begin
                  take = 1'b1;
               end
            end
            if (take || CNT_W'(j_ff) == win_len - 1'b1) begin
               cmd_push = keep;
               have_in  = keep;
               if (take) begin
                  ws_in     = ws_ff + RING_AW'(j_ff);
                  pend_in   = 1'b1;
                  locked_in = 1'b1;
                  tc_in     = timeout_limit;
                  zt_in     = (j_ff == '0);
               end else begin
                  ws_in = ws_ff + RING_AW'(win_len);
                  zt_in = 1'b0;
               end
               state_in = keep ? ST_IDLE : ST_CHECK;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         wp_ff     <= '0;
         ws_ff     <= '0;
         locked_ff <= 1'b0;
         tc_ff     <= '0;
         pend_ff   <= 1'b0;
         zt_ff     <= 1'b0;
         j_ff      <= '0;
         have_ff   <= 1'b0;
         pre_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         wp_ff     <= wp_in;
         ws_ff     <= ws_in;
         locked_ff <= locked_in;
         tc_ff     <= tc_in;
         pend_ff   <= pend_in;
         zt_ff     <= zt_in;
         j_ff      <= j_in;
         have_ff   <= have_in;
         pre_ff    <= pre_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ring_mem[wp_ff] <= '{trigger: req_trigger, q: req_sample_q, i: req_sample_i};
      end
      scan_data_ff <= ring_mem[scan_addr];
      emit_data_ff <= ring_mem[emit_addr];
   end

endmodule

// ===== sv/oss_back.sv =====
// Emitter: reads a kept symbol out of the ring and presents it sample by sample.
module oss_back
   import oss_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cmd_ready,
   input  emit_cmd_type            cmd_data,
   output logic                    cmd_pop,
   output logic [RING_AW-1:0]      emit_addr,
   input  ring_entry_type          emit_data,
   output logic                    busy,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [SMP_W-1:0] rsp_out_i,
   output logic signed [SMP_W-1:0] rsp_out_q,
   output logic [IDX_W-1:0]        rsp_sample_index,
   output logic                    rsp_preamble,
   output logic                    rsp_last
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_LOAD = 2'd2;
   localparam logic [1:0] ST_HOLD = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [RING_AW-1:0]      base_ff, base_in;
   logic                    pre_ff, pre_in;
   logic [K_W-1:0]          k_ff, k_in;
   logic                    valid_ff, valid_in;
   logic signed [SMP_W-1:0] i_ff, q_ff;
   logic                    load;

   assign emit_addr        = base_ff + RING_AW'(k_ff);
   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = valid_ff;
   assign rsp_out_i        = i_ff;
   assign rsp_out_q        = q_ff;
   assign rsp_sample_index = IDX_W'(k_ff);
   assign rsp_preamble     = pre_ff;
   assign rsp_last         = (k_ff == K_W'(FFT_LEN - 1));

   always_comb begin
      state_in = state_ff;
      base_in  = base_ff;
      pre_in   = pre_ff;
      k_in     = k_ff;
      valid_in = valid_ff;
      cmd_pop  = 1'b0;
      load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_ready) begin
               cmd_pop  = 1'b1;
               base_in  = cmd_data.start;
               pre_in   = cmd_data.preamble;
               k_in     = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            load     = 1'b1;
            valid_in = 1'b1;
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (!rsp_stall) begin
               valid_in = 1'b0;
               if (k_ff == K_W'(FFT_LEN - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         k_ff     <= '0;
         base_ff  <= '0;
         pre_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         k_ff     <= k_in;
         base_ff  <= base_in;
         pre_ff   <= pre_in;
      end
      if (load) begin
         i_ff <= emit_data.i;
         q_ff <= emit_data.q;
      end
   end

endmodule

// ===== sv/ofdm_symbol_sampler.sv =====
// OFDM symbol sampler: takes one sample per transaction, tracks symbol
// windows in a 128-entry ring, and emits each kept symbol as 64 result
// transactions. Items are processed one at a time: a sample that closes no
// window is only checked against the window length, while closing a window
// scans it sample by sample, reading and then evaluating each (up to 80
// samples, repeated when a window closes again at once), and each result
// of a symbol is read, loaded and held on the emitter's single ring read port.
// Input is stalled until a started emission has been fully delivered.
module ofdm_symbol_sampler
   import oss_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [SMP_W-1:0] req_sample_i,
   input  logic signed [SMP_W-1:0] req_sample_q,
   input  logic                    req_trigger,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [SMP_W-1:0] rsp_out_i,
   output logic signed [SMP_W-1:0] rsp_out_q,
   output logic [IDX_W-1:0]        rsp_sample_index,
   output logic                    rsp_preamble,
   output logic                    rsp_last,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [2:0]              paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   logic [CP_W-1:0]    cp_ff;
   logic [TO_W-1:0]    limit_ff;
   logic               cmd_push, cmd_pop, cmd_ready;
   emit_cmd_type       push_cmd, pop_cmd;
   logic [RING_AW-1:0] emit_addr;
   ring_entry_type     emit_data;
   logic               back_active;
   logic               back_busy;

   assign pready    = 1'b1;
   assign back_busy = back_active || cmd_ready;

   always_comb begin
      unique case (paddr[2])
         REG_PREFIX_LEN:    prdata = 32'(cp_ff);
         REG_TIMEOUT_LIMIT: prdata = 32'(limit_ff);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cp_ff    <= CP_W'(16);
         limit_ff <= TO_W'(1024);
      end else if (psel && penable && pwrite && pready) begin
         unique case (paddr[2])
            REG_PREFIX_LEN:    cp_ff    <= pwdata[CP_W-1:0];
            REG_TIMEOUT_LIMIT: limit_ff <= pwdata[TO_W-1:0];
            default: ;
         endcase
      end
   end

   oss_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sample_i  (req_sample_i),
      .req_sample_q  (req_sample_q),
      .req_trigger   (req_trigger),
      .prefix_len    (cp_ff),
      .timeout_limit (limit_ff),
      .back_busy     (back_busy),
      .cmd_push      (cmd_push),
      .cmd_data      (push_cmd),
      .emit_addr     (emit_addr),
      .emit_data     (emit_data)
   );

   oss_cmd_fifo u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (push_cmd),
      .pop       (cmd_pop),
      .pop_data  (pop_cmd),
      .not_empty (cmd_ready)
   );

   oss_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_ready        (cmd_ready),
      .cmd_data         (pop_cmd),
      .cmd_pop          (cmd_pop),
      .emit_addr        (emit_addr),
      .emit_data        (emit_data),
      .busy             (back_active),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_i        (rsp_out_i),
      .rsp_out_q        (rsp_out_q),
      .rsp_sample_index (rsp_sample_index),
      .rsp_preamble     (rsp_preamble),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== test/tb.sv =====
// Testbench for ofdm_symbol_sampler: directed and random samples checked against a tracker.
module tb
   import oss_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [SMP_W-1:0] i;
      logic signed [SMP_W-1:0] q;
      logic                    trigger;
   } smp_row_type;

   typedef struct packed {
      logic signed [SMP_W-1:0] i;
      logic signed [SMP_W-1:0] q;
      logic [IDX_W-1:0]        idx;
      logic                    pre;
      logic                    last;
   } sym_smp_type;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 2000;
   localparam logic [2:0] ADDR_CP      = {REG_PREFIX_LEN, 2'b00};
   localparam logic [2:0] ADDR_TIMEOUT = {REG_TIMEOUT_LIMIT, 2'b00};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [SMP_W-1:0] req_sample_i = '0;
   logic signed [SMP_W-1:0] req_sample_q = '0;
   logic req_trigger = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   logic signed [SMP_W-1:0] rsp_out_i, rsp_out_q;
   logic [IDX_W-1:0] rsp_sample_index;
   logic rsp_preamble, rsp_last;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   ofdm_symbol_sampler i_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Symbol tracker state.
   logic [32:0]        ring [RING_DEPTH];
   logic [RING_AW-1:0] wr_ptr, win_start;
   logic               is_locked, pre_pending, zero_taken;
   logic [TO_W-1:0]    timeout_cnt, timeout_reload;
   logic [CP_W-1:0]    cp_reg;

   sym_smp_type symbol_fifo[$];
   int errors = 0;
   int mismatches = 0;
   int results_seen = 0;
   int idle_cycles = 0;
   bit hold_off_req = 0;

   function automatic int cp_eff();
      return (cp_reg > CP_MAX) ? CP_MAX : int'(cp_reg);
   endfunction

   // Closes the current window and returns 1 when a symbol was emitted.
   function automatic bit close_window();
      int len, at;
      bit have, pre, found;
      logic [32:0] e;
      sym_smp_type r;
      len = FFT_LEN + cp_eff();
      have = 0; pre = 0; found = 0; at = 0;
      if (is_locked) begin
         timeout_cnt = timeout_cnt - 1'b1;
         if (timeout_cnt == 0) begin
            is_locked = 0;
         end else begin
            have = 1;
            pre = pre_pending;
            pre_pending = 0;
         end
      end
      for (int j = 0; j < len; j++) begin
         e = ring[RING_AW'(win_start + j)];
         if (!e[32]) continue;
         if (j == 0 && zero_taken) continue;
         if (j <= cp_eff() && have) begin
            if (pre) continue;
            have = 0;
         end
         found = 1;
         at = j;
         break;
      end
      if (have) begin
         for (int k = 0; k < FFT_LEN; k++) begin
            e = ring[RING_AW'(win_start + k)];
            r.i = e[15:0];
            r.q = e[31:16];
            r.idx = IDX_W'(k);
            r.pre = pre;
            r.last = (k == FFT_LEN - 1);
            symbol_fifo.push_back(r);
         end
      end
      if (found) begin
         win_start = RING_AW'(win_start + at);
         pre_pending = 1;
         is_locked = 1;
         timeout_cnt = timeout_reload;
         zero_taken = (at == 0);
      end else begin
         win_start = RING_AW'(win_start + len);
         zero_taken = 0;
      end
      return have;
   endfunction

   function automatic void track_sample(smp_row_type s);
      ring[wr_ptr] = {s.trigger, s.q, s.i};
      wr_ptr = wr_ptr + 1'b1;
      for (int g = 0; g < 2 * RING_DEPTH; g++) begin
         if (int'(RING_AW'(wr_ptr - win_start)) < FFT_LEN + cp_eff()) break;
         if (close_window()) break;
      end
   endfunction

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      @(negedge clock);
      psel = 1; penable = 0; pwrite = 1; paddr = addr; pwdata = data;
      @(negedge clock);
      penable = 1;
      @(posedge clock);
      if (addr == ADDR_CP) cp_reg = data[CP_W-1:0];
      else timeout_reload = data[TO_W-1:0];
      @(negedge clock);
      psel = 0; penable = 0; pwrite = 0;
   endtask

   // Offers one sample and returns once the transaction has been accepted.
   task automatic send_sample(smp_row_type s);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1;
      req_sample_i = s.i; req_sample_q = s.q; req_trigger = s.trigger;
      do @(posedge clock); while (req_stall);
      track_sample(s);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid = 0;
      while (symbol_fifo.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Random samples, mostly with triggers one symbol length apart.
   task automatic random_phase(int n);
      smp_row_type s;
      int since;
      since = 0;
      for (int k = 0; k < n; k++) begin
         s.i = $urandom; s.q = $urandom;
         if (since >= FFT_LEN + cp_eff()) s.trigger = ($urandom_range(0, 9) < 8);
         else s.trigger = ($urandom_range(0, 49) == 0);
         since = s.trigger ? 0 : since + 1;
         if (k == n / 2 && n > 40) begin
            @(negedge clock);
            req_valid = 0;
            while (symbol_fifo.size() != 0) @(posedge clock);
         end
         send_sample(s);
      end
   endtask

   smp_row_type directed [] = '{
      '{16'sh7FFF, 16'sh7FFF, 1'b0}, '{-16'sh8000, -16'sh8000, 1'b0},
      '{16'sh0000, 16'sh0000, 1'b1}, '{16'sh5555, 16'shAAAA, 1'b0},
      '{16'shAAAA, 16'sh5555, 1'b1}, '{16'sh0001, 16'shFFFF, 1'b0},
      '{16'shFFFF, 16'sh0001, 1'b0}, '{16'sh7FFF, -16'sh8000, 1'b1},
      '{-16'sh8000, 16'sh7FFF, 1'b0}, '{16'sh1234, 16'shEDCB, 1'b1},
      '{16'sh0F0F, 16'shF0F0, 1'b0}, '{16'shF0F0, 16'sh0F0F, 1'b0}
   };

   // Receiver: random stall per transaction, one long hold-off on request.
   initial begin
      int n;
      @(negedge clock);
      forever begin
         if (hold_off_req) begin
            rsp_stall = 1;
            repeat (400) @(negedge clock);
            hold_off_req = 0;
         end
         n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
         rsp_stall = (n > 0);
         repeat (n) @(negedge clock);
         rsp_stall = 0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      sym_smp_type exp_s;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (results_seen == 70) hold_off_req <= 1;
         if (symbol_fifo.size() == 0) begin
            errors++;
            if (mismatches++ < 10) $display("unexpected result transaction idx=%0d",
                                            rsp_sample_index);
         end else begin
            exp_s = symbol_fifo.pop_front();
            if (exp_s.i !== rsp_out_i || exp_s.q !== rsp_out_q ||
                exp_s.idx !== rsp_sample_index || exp_s.pre !== rsp_preamble ||
                exp_s.last !== rsp_last) begin
               errors++;
               if (mismatches++ < 10)
                  $display({"mismatch: expected i=%0d q=%0d idx=%0d pre=%0b last=%0b,",
                            " got i=%0d q=%0d idx=%0d pre=%0b last=%0b"},
                           exp_s.i, exp_s.q, exp_s.idx, exp_s.pre, exp_s.last, rsp_out_i,
                           rsp_out_q, rsp_sample_index, rsp_preamble, rsp_last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[ofdm_symbol_sampler] ERROR");
         $finish;
      end
   end

   initial begin
      wr_ptr = '0; win_start = '0; is_locked = 0; pre_pending = 0; zero_taken = 0;
      timeout_cnt = '0; timeout_reload = 16'd1024; cp_reg = 5'd16;
      foreach (ring[k]) ring[k] = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;
      foreach (directed[k]) send_sample(directed[k]);
      random_phase(70);
      settle();
      csr_write(ADDR_CP, 32'd0);
      csr_write(ADDR_TIMEOUT, 32'd65535);
      random_phase(70);
      settle();
      csr_write(ADDR_CP, 32'd31);
      csr_write(ADDR_TIMEOUT, 32'd1);
      random_phase(50);
      settle();
      csr_write(ADDR_CP, 32'd5);
      csr_write(ADDR_TIMEOUT, 32'd0);
      random_phase(60);
      settle();
      csr_write(ADDR_CP, 32'd16);
      csr_write(ADDR_TIMEOUT, 32'd3);
      random_phase(70);
      settle();
      if (symbol_fifo.size() != 0) errors++;
      if (errors == 0) begin
         $display("[ofdm_symbol_sampler] OK");
      end else begin
         $display("[ofdm_symbol_sampler] ERROR");
      end
      $finish;
   end
endmodule
